// ----- design/assert_macros.svh -----
// Assertion macros used by the top design file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define GCDB_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define GCDB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/gcdb_pkg.sv -----
// Shared widths, constants and helper functions for the great-circle block.
// Used by the channel interfaces and every module of the block.
`timescale 1ns / 1ps

package gcdb_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int CORDIC_RUN    = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

    localparam int LAT_W   = 31;
    localparam int LON_W   = 32;
    localparam int DIST_W  = 31;
    localparam int HEAD_W  = 33;

    localparam int WRAP_W  = 35;
    localparam int ANG_W   = 32;
    localparam int Q_W     = 32;
    localparam int XY_W    = 34;
    localparam int VEC_W   = 36;
    localparam int Z_W     = 34;
    localparam int A_W     = 31;
    localparam int SQ_W    = 62;
    localparam int SQ_STEPS = 31;
    localparam int ROOT_W  = 31;
    localparam int PROD_W  = 61;

    localparam logic signed [WRAP_W-1:0] ANG_PI      = 35'sd1686629713;
    localparam logic signed [WRAP_W-1:0] ANG_HALF_PI = 35'sd843314857;
    localparam logic signed [WRAP_W-1:0] ANG_TWO_PI  = 35'sd3373259426;

    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
    localparam logic signed [XY_W-1:0]  Q30_ONE_XY  = 34'sd1073741824;
    localparam logic [A_W-1:0]          Q30_ONE_A   = 31'd1073741824;

    localparam logic [29:0]             EARTH_RADIUS_CM = 30'd637100000;
    localparam logic [DIST_W-1:0]       DIST_MAX    = 31'd2001508680;
    localparam logic signed [Z_W-1:0]   HEAD_MIN    = -34'sd843314857;
    localparam logic signed [Z_W-1:0]   HEAD_MAX    = 34'sd2529944570;

    typedef struct packed {
        logic signed [ANG_W-1:0] ang;
        logic                    neg;
    } fold_t;

    // Arctangent of 2^-idx in Q29 radians.
    function automatic logic [29:0] stage_angle(input int unsigned idx);
        logic [29:0] v;
        unique case (idx)
            0:  v = 30'd421657428;
            1:  v = 30'd248918914;
            2:  v = 30'd131521918;
            3:  v = 30'd66762579;
            4:  v = 30'd33510843;
            5:  v = 30'd16771758;
            6:  v = 30'd8387925;
            7:  v = 30'd4194219;
            8:  v = 30'd2097141;
            9:  v = 30'd1048575;
            10: v = 30'd524288;
            11: v = 30'd262144;
            12: v = 30'd131072;
            13: v = 30'd65536;
            14: v = 30'd32768;
            15: v = 30'd16384;
            16: v = 30'd8192;
            17: v = 30'd4096;
            18: v = 30'd2048;
            19: v = 30'd1024;
            20: v = 30'd512;
            21: v = 30'd256;
            22: v = 30'd128;
            23: v = 30'd64;
            24: v = 30'd32;
            25: v = 30'd16;
            26: v = 30'd8;
            27: v = 30'd4;
            28: v = 30'd2;
            29: v = 30'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Wrap into (-pi, pi], then fold into [-pi/2, pi/2]; neg marks a fold.
    // The input angles never lie more than one turn outside the range.
    function automatic fold_t fold_angle(input logic signed [WRAP_W-1:0] a);
        logic signed [WRAP_W-1:0] w;
        fold_t f;
        w = a;
        if (w > ANG_PI)
            w = w - ANG_TWO_PI;
        else if (w <= -ANG_PI)
            w = w + ANG_TWO_PI;
        f.neg = 1'b0;
        if (w > ANG_HALF_PI)
        begin
            w = w - ANG_PI;
            f.neg = 1'b1;
        end
        else if (w < -ANG_HALF_PI)
        begin
            w = w + ANG_PI;
            f.neg = 1'b1;
        end
        f.ang = w[ANG_W-1:0];
        return f;
    endfunction

    // Q30 product, floor rounding.
    function automatic logic signed [Q_W-1:0] mulq(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] p;
        p = a * b;
        return p[Q_W+29:30];
    endfunction

endpackage

// ----- design/gcdb_intf.sv -----
// Valid/ready channels for point pairs in and distance/heading results out.
// Depends on gcdb_pkg for field widths.
`timescale 1ns / 1ps

interface gcdb_pt_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [gcdb_pkg::LAT_W-1:0]     from_latitude;
    logic signed [gcdb_pkg::LON_W-1:0]     from_longitude;
    logic signed [gcdb_pkg::LAT_W-1:0]     to_latitude;
    logic signed [gcdb_pkg::LON_W-1:0]     to_longitude;

    modport source (output valid, from_latitude, from_longitude, to_latitude, to_longitude,
                    input ready);
    modport sink (input valid, from_latitude, from_longitude, to_latitude, to_longitude,
                  output ready);
endinterface

interface gcdb_res_if;
    logic                                  valid;
    logic                                  ready;
    logic [gcdb_pkg::DIST_W-1:0]           distance_cm;
    logic signed [gcdb_pkg::HEAD_W-1:0]    heading_from_east;

    modport source (output valid, distance_cm, heading_from_east, input ready);
    modport sink (input valid, distance_cm, heading_from_east, output ready);
endinterface

// ----- design/great_circle_distance_bearing.sv -----
// Haversine distance and initial heading: one point pair accepted per cycle
// while the result is taken, set by the fully pipelined CORDIC and square-root
// stages. A stalled result stalls the whole pipe. Reset clears only the valid
// bits; data registers are not reset.
// Depends on gcdb_pkg, gcdb_intf, gcdb_sincos, gcdb_atan2, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module great_circle_distance_bearing (
    input  logic        clk,
    input  logic        rst_n,
    gcdb_pt_if.sink     pts,
    gcdb_res_if.source  res
);

    localparam int N       = gcdb_pkg::CORDIC_RUN;
    localparam int LATENCY = 2 * N + 39;
    localparam int NANG    = 5;
    localparam int I_LAT1  = 0;
    localparam int I_LAT2  = 1;
    localparam int I_HLAT  = 2;
    localparam int I_HLON  = 3;
    localparam int I_DLON  = 4;
    localparam int SQ_LAST = gcdb_pkg::SQ_STEPS - 1;

    // Valid bits and global advance.
    logic [LATENCY-1:0] vld_reg;
    logic               adv;

    assign adv       = !vld_reg[LATENCY-1] || res.ready;
    assign pts.ready = adv;
    assign res.valid = vld_reg[LATENCY-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LATENCY-2:0], pts.valid};
    end

    // Angle preparation.
    logic signed [gcdb_pkg::WRAP_W-1:0] lat1, lat2, lon1, lon2, dlat, dlon;
    gcdb_pkg::fold_t                    fold_w [NANG];
    gcdb_pkg::fold_t                    fold_reg [NANG];

    always_comb
    begin
        lat1 = gcdb_pkg::WRAP_W'(pts.from_latitude);
        lat2 = gcdb_pkg::WRAP_W'(pts.to_latitude);
        lon1 = gcdb_pkg::WRAP_W'(pts.from_longitude);
        lon2 = gcdb_pkg::WRAP_W'(pts.to_longitude);
        dlat = lat2 - lat1;
        dlon = lon2 - lon1;
        fold_w[I_LAT1] = gcdb_pkg::fold_angle(lat1);
        fold_w[I_LAT2] = gcdb_pkg::fold_angle(lat2);
        fold_w[I_HLAT] = gcdb_pkg::fold_angle(dlat >>> 1);
        fold_w[I_HLON] = gcdb_pkg::fold_angle(dlon >>> 1);
        fold_w[I_DLON] = gcdb_pkg::fold_angle(dlon);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            fold_reg <= fold_w;
    end

    // Sines and cosines.
    logic signed [gcdb_pkg::Q_W-1:0] sin_w [NANG];
    logic signed [gcdb_pkg::Q_W-1:0] cos_w [NANG];
    logic signed [gcdb_pkg::Q_W-1:0] sn_reg [NANG];
    logic signed [gcdb_pkg::Q_W-1:0] cs_reg [NANG];

    for (genvar j = 0; j < NANG; j++)
    begin : g_trig
        gcdb_sincos u_sincos (
            .clk   (clk),
            .en    (adv),
            .angle (fold_reg[j].ang),
            .neg   (fold_reg[j].neg),
            .sin_q (sin_w[j]),
            .cos_q (cos_w[j])
        );
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sn_reg <= sin_w;
            cs_reg <= cos_w;
        end
    end

    // First products.
    logic signed [gcdb_pkg::Q_W-1:0] p_shsh_reg, p_c1c2_reg, p_slsl_reg, p_bx_reg;
    logic signed [gcdb_pkg::Q_W-1:0] p_c1s2_reg, p_s1c2_reg, p_cd_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_shsh_reg <= gcdb_pkg::mulq(sn_reg[I_HLAT], sn_reg[I_HLAT]);
            p_c1c2_reg <= gcdb_pkg::mulq(cs_reg[I_LAT1], cs_reg[I_LAT2]);
            p_slsl_reg <= gcdb_pkg::mulq(sn_reg[I_HLON], sn_reg[I_HLON]);
            p_bx_reg   <= gcdb_pkg::mulq(sn_reg[I_DLON], cs_reg[I_LAT2]);
            p_c1s2_reg <= gcdb_pkg::mulq(cs_reg[I_LAT1], sn_reg[I_LAT2]);
            p_s1c2_reg <= gcdb_pkg::mulq(sn_reg[I_LAT1], cs_reg[I_LAT2]);
            p_cd_reg   <= cs_reg[I_DLON];
        end
    end

    // Second products.
    logic signed [gcdb_pkg::Q_W-1:0] q_shsh_reg, q_hav_reg, q_bx_reg, q_c1s2_reg, q_cross_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_shsh_reg  <= p_shsh_reg;
            q_hav_reg   <= gcdb_pkg::mulq(p_c1c2_reg, p_slsl_reg);
            q_bx_reg    <= p_bx_reg;
            q_c1s2_reg  <= p_c1s2_reg;
            q_cross_reg <= gcdb_pkg::mulq(p_s1c2_reg, p_cd_reg);
        end
    end

    // Haversine term and heading vector.
    logic signed [gcdb_pkg::Q_W:0]       a_sum;
    logic [gcdb_pkg::A_W-1:0]            a_next, a_reg;
    logic signed [gcdb_pkg::VEC_W-1:0]   bx_reg, by_reg;

    always_comb
    begin
        a_sum = (gcdb_pkg::Q_W+1)'(q_shsh_reg) + (gcdb_pkg::Q_W+1)'(q_hav_reg);
        if (a_sum < 0)
            a_next = '0;
        else if (a_sum > (gcdb_pkg::Q_W+1)'(gcdb_pkg::Q30_ONE_A))
            a_next = gcdb_pkg::Q30_ONE_A;
        else
            a_next = a_sum[gcdb_pkg::A_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg  <= a_next;
            bx_reg <= gcdb_pkg::VEC_W'(q_bx_reg);
            by_reg <= gcdb_pkg::VEC_W'(q_c1s2_reg) - gcdb_pkg::VEC_W'(q_cross_reg);
        end
    end

    // Two square roots, one result bit per stage, heading vector alongside.
    logic [gcdb_pkg::SQ_W-1:0]         ry_n_reg [gcdb_pkg::SQ_STEPS];
    logic [gcdb_pkg::SQ_W-1:0]         ry_r_reg [gcdb_pkg::SQ_STEPS];
    logic [gcdb_pkg::SQ_W-1:0]         rx_n_reg [gcdb_pkg::SQ_STEPS];
    logic [gcdb_pkg::SQ_W-1:0]         rx_r_reg [gcdb_pkg::SQ_STEPS];
    logic signed [gcdb_pkg::VEC_W-1:0] bxd_reg [gcdb_pkg::SQ_STEPS];
    logic signed [gcdb_pkg::VEC_W-1:0] byd_reg [gcdb_pkg::SQ_STEPS];

    for (genvar k = 0; k < gcdb_pkg::SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [gcdb_pkg::SQ_W-1:0] BIT = gcdb_pkg::SQ_W'(1) << (60 - 2 * k);

        logic [gcdb_pkg::SQ_W-1:0]         yn, yr, xn, xr, yn_next, yr_next, xn_next, xr_next;
        logic signed [gcdb_pkg::VEC_W-1:0] bx_i, by_i;

        if (k == 0)
        begin : g_first
            assign yn   = gcdb_pkg::SQ_W'({a_reg, 30'b0});
            assign xn   = gcdb_pkg::SQ_W'({gcdb_pkg::Q30_ONE_A - a_reg, 30'b0});
            assign yr   = '0;
            assign xr   = '0;
            assign bx_i = bx_reg;
            assign by_i = by_reg;
        end
        else
        begin : g_rest
            assign yn   = ry_n_reg[k-1];
            assign xn   = rx_n_reg[k-1];
            assign yr   = ry_r_reg[k-1];
            assign xr   = rx_r_reg[k-1];
            assign bx_i = bxd_reg[k-1];
            assign by_i = byd_reg[k-1];
        end

        always_comb
        begin
            if (yn >= yr + BIT)
            begin
                yn_next = yn - (yr + BIT);
                yr_next = (yr >> 1) + BIT;
            end
            else
            begin
                yn_next = yn;
                yr_next = yr >> 1;
            end
            if (xn >= xr + BIT)
            begin
                xn_next = xn - (xr + BIT);
                xr_next = (xr >> 1) + BIT;
            end
            else
            begin
                xn_next = xn;
                xr_next = xr >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ry_n_reg[k] <= yn_next;
                ry_r_reg[k] <= yr_next;
                rx_n_reg[k] <= xn_next;
                rx_r_reg[k] <= xr_next;
                bxd_reg[k]  <= bx_i;
                byd_reg[k]  <= by_i;
            end
        end
    end

    // Central half-angle and heading angle.
    logic signed [gcdb_pkg::VEC_W-1:0] root_y, root_x;
    logic signed [gcdb_pkg::Z_W-1:0]   zd_w, zh_w;

    assign root_y = signed'(gcdb_pkg::VEC_W'(ry_r_reg[SQ_LAST][gcdb_pkg::ROOT_W-1:0]));
    assign root_x = signed'(gcdb_pkg::VEC_W'(rx_r_reg[SQ_LAST][gcdb_pkg::ROOT_W-1:0]));

    gcdb_atan2 u_atan_dist (
        .clk   (clk),
        .en    (adv),
        .v_in  (root_y),
        .h_in  (root_x),
        .angle (zd_w)
    );

    gcdb_atan2 u_atan_head (
        .clk   (clk),
        .en    (adv),
        .v_in  (bxd_reg[SQ_LAST]),
        .h_in  (byd_reg[SQ_LAST]),
        .angle (zh_w)
    );

    // Scale to centimeters and turn the bearing into a heading from east.
    logic [29:0]                        zc;
    logic signed [gcdb_pkg::Z_W:0]      hd;
    logic signed [gcdb_pkg::HEAD_W-1:0] head_next, head_reg, head_out_reg;
    logic [gcdb_pkg::PROD_W-1:0]        prod_reg;

    always_comb
    begin
        if (zd_w < 0)
            zc = '0;
        else if (zd_w > gcdb_pkg::Z_W'(gcdb_pkg::ANG_HALF_PI))
            zc = gcdb_pkg::ANG_HALF_PI[29:0];
        else
            zc = zd_w[29:0];
        hd = (gcdb_pkg::Z_W+1)'(gcdb_pkg::ANG_HALF_PI) - (gcdb_pkg::Z_W+1)'(zh_w);
        if (hd < (gcdb_pkg::Z_W+1)'(gcdb_pkg::HEAD_MIN))
            head_next = gcdb_pkg::HEAD_MIN[gcdb_pkg::HEAD_W-1:0];
        else if (hd > (gcdb_pkg::Z_W+1)'(gcdb_pkg::HEAD_MAX))
            head_next = gcdb_pkg::HEAD_MAX[gcdb_pkg::HEAD_W-1:0];
        else
            head_next = hd[gcdb_pkg::HEAD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= gcdb_pkg::PROD_W'(gcdb_pkg::EARTH_RADIUS_CM)
                        * gcdb_pkg::PROD_W'({zc, 1'b0});
            head_reg <= head_next;
        end
    end

    logic [gcdb_pkg::PROD_W-29:0] dist_w;
    logic [gcdb_pkg::DIST_W-1:0]  dist_next, dist_out_reg;

    always_comb
    begin
        dist_w = (gcdb_pkg::PROD_W-28)'((prod_reg + (gcdb_pkg::PROD_W'(1) << 28)) >> 29);
        if (dist_w > (gcdb_pkg::PROD_W-28)'(gcdb_pkg::DIST_MAX))
            dist_next = gcdb_pkg::DIST_MAX;
        else
            dist_next = dist_w[gcdb_pkg::DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_out_reg <= dist_next;
            head_out_reg <= head_reg;
        end
    end

    assign res.distance_cm       = dist_out_reg;
    assign res.heading_from_east = head_out_reg;

    logic dist_in_range, head_in_range;

    assign dist_in_range = res.distance_cm <= gcdb_pkg::DIST_MAX;
    assign head_in_range = (gcdb_pkg::Z_W'(res.heading_from_east) >= gcdb_pkg::HEAD_MIN)
                        && (gcdb_pkg::Z_W'(res.heading_from_east) <= gcdb_pkg::HEAD_MAX);

    `GCDB_ASSERT_SAME(a_dist_range, res.valid, dist_in_range, "distance above range")
    `GCDB_ASSERT_SAME(a_head_range, res.valid, head_in_range, "heading out of range")
    `GCDB_ASSERT_SAME(a_stall_blocks_input, res.valid && !res.ready, !pts.ready, "input in stall")
    `GCDB_ASSERT_NEXT(a_accept_tracked, pts.valid && pts.ready, vld_reg[0], "beat lost")

endmodule

// ----- design/gcdb_sincos.sv -----
// Pipelined rotation CORDIC: sine and cosine of a folded Q29 angle, Q30 out.
// One register stage per iteration; depends on gcdb_pkg.
`timescale 1ns / 1ps

module gcdb_sincos (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [gcdb_pkg::ANG_W-1:0]   angle,
    input  logic                                neg,
    output logic signed [gcdb_pkg::Q_W-1:0]     sin_q,
    output logic signed [gcdb_pkg::Q_W-1:0]     cos_q
);

    localparam int N = gcdb_pkg::CORDIC_RUN;

    logic signed [gcdb_pkg::XY_W-1:0]  x_reg [N];
    logic signed [gcdb_pkg::XY_W-1:0]  y_reg [N];
    logic signed [gcdb_pkg::ANG_W-1:0] z_reg [N];
    logic                              neg_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic signed [gcdb_pkg::ANG_W-1:0] STEP =
            gcdb_pkg::ANG_W'(gcdb_pkg::stage_angle(i));

        logic signed [gcdb_pkg::XY_W-1:0]  x_in, y_in, x_next, y_next;
        logic signed [gcdb_pkg::ANG_W-1:0] z_in, z_next;
        logic                              neg_in;

        if (i == 0)
        begin : g_first
            assign x_in   = gcdb_pkg::GAIN_Q30;
            assign y_in   = '0;
            assign z_in   = angle;
            assign neg_in = neg;
        end
        else
        begin : g_rest
            assign x_in   = x_reg[i-1];
            assign y_in   = y_reg[i-1];
            assign z_in   = z_reg[i-1];
            assign neg_in = neg_reg[i-1];
        end

        always_comb
        begin
            if (z_in >= 0)
            begin
                x_next = x_in - (y_in >>> i);
                y_next = y_in + (x_in >>> i);
                z_next = z_in - STEP;
            end
            else
            begin
                x_next = x_in + (y_in >>> i);
                y_next = y_in - (x_in >>> i);
                z_next = z_in + STEP;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]   <= x_next;
                y_reg[i]   <= y_next;
                z_reg[i]   <= z_next;
                neg_reg[i] <= neg_in;
            end
        end
    end

    logic signed [gcdb_pkg::XY_W-1:0] xc, yc, xs, ys;

    always_comb
    begin
        xc = x_reg[N-1];
        yc = y_reg[N-1];
        if (xc > gcdb_pkg::Q30_ONE_XY)
            xc = gcdb_pkg::Q30_ONE_XY;
        else if (xc < -gcdb_pkg::Q30_ONE_XY)
            xc = -gcdb_pkg::Q30_ONE_XY;
        if (yc > gcdb_pkg::Q30_ONE_XY)
            yc = gcdb_pkg::Q30_ONE_XY;
        else if (yc < -gcdb_pkg::Q30_ONE_XY)
            yc = -gcdb_pkg::Q30_ONE_XY;
        xs = neg_reg[N-1] ? -xc : xc;
        ys = neg_reg[N-1] ? -yc : yc;
    end

    assign sin_q = ys[gcdb_pkg::Q_W-1:0];
    assign cos_q = xs[gcdb_pkg::Q_W-1:0];

endmodule

// ----- design/gcdb_atan2.sv -----
// Pipelined vectoring CORDIC: angle of the vector (h, v) in Q29 radians.
// A normalizing stage precedes one register stage per iteration; uses gcdb_pkg.
`timescale 1ns / 1ps

module gcdb_atan2 (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [gcdb_pkg::VEC_W-1:0]   v_in,
    input  logic signed [gcdb_pkg::VEC_W-1:0]   h_in,
    output logic signed [gcdb_pkg::Z_W-1:0]     angle
);

    localparam int N = gcdb_pkg::CORDIC_RUN;

    logic signed [gcdb_pkg::VEC_W-1:0] nv, nh, lim;
    logic signed [gcdb_pkg::Z_W-1:0]   noff;
    logic                              nzero;

    // Left half-plane vectors are mirrored; then both parts are doubled
    // until one of them reaches one in Q30, in binary steps of 16 down to 1.
    always_comb
    begin
        nv    = v_in;
        nh    = h_in;
        noff  = '0;
        nzero = (v_in == '0) && (h_in == '0);
        if (h_in < 0)
        begin
            noff = (v_in >= 0) ? gcdb_pkg::Z_W'(gcdb_pkg::ANG_PI)
                               : -gcdb_pkg::Z_W'(gcdb_pkg::ANG_PI);
            nh = -h_in;
            nv = -v_in;
        end
        for (int k = 4; k >= 0; k--)
        begin
            lim = gcdb_pkg::VEC_W'(1) << (31 - (1 << k));
            if (nh < lim && nv < lim && nv > -lim)
            begin
                nh = nh <<< (1 << k);
                nv = nv <<< (1 << k);
            end
        end
    end

    logic signed [gcdb_pkg::VEC_W-1:0] v0_reg, h0_reg;
    logic signed [gcdb_pkg::Z_W-1:0]   off0_reg;
    logic                              zero0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg    <= nv;
            h0_reg    <= nh;
            off0_reg  <= noff;
            zero0_reg <= nzero;
        end
    end

    logic signed [gcdb_pkg::VEC_W-1:0] v_reg [N];
    logic signed [gcdb_pkg::VEC_W-1:0] h_reg [N];
    logic signed [gcdb_pkg::Z_W-1:0]   z_reg [N];
    logic signed [gcdb_pkg::Z_W-1:0]   off_reg [N];
    logic                              zero_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic signed [gcdb_pkg::Z_W-1:0] STEP =
            gcdb_pkg::Z_W'(gcdb_pkg::stage_angle(i));

        logic signed [gcdb_pkg::VEC_W-1:0] v_i, h_i, v_next, h_next;
        logic signed [gcdb_pkg::Z_W-1:0]   z_i, z_next, off_i;
        logic                              zero_i;

        if (i == 0)
        begin : g_first
            assign v_i    = v0_reg;
            assign h_i    = h0_reg;
            assign z_i    = '0;
            assign off_i  = off0_reg;
            assign zero_i = zero0_reg;
        end
        else
        begin : g_rest
            assign v_i    = v_reg[i-1];
            assign h_i    = h_reg[i-1];
            assign z_i    = z_reg[i-1];
            assign off_i  = off_reg[i-1];
            assign zero_i = zero_reg[i-1];
        end

        always_comb
        begin
            if (v_i < 0)
            begin
                h_next = h_i - (v_i >>> i);
                v_next = v_i + (h_i >>> i);
                z_next = z_i - STEP;
            end
            else
            begin
                h_next = h_i + (v_i >>> i);
                v_next = v_i - (h_i >>> i);
                z_next = z_i + STEP;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[i]    <= v_next;
                h_reg[i]    <= h_next;
                z_reg[i]    <= z_next;
                off_reg[i]  <= off_i;
                zero_reg[i] <= zero_i;
            end
        end
    end

    assign angle = zero_reg[N-1] ? '0 : (z_reg[N-1] + off_reg[N-1]);

endmodule

// ----- verif/gcdb_checker.sv -----
// Checker for the great-circle block: watches both channels, predicts each result
// from the accepted point pair and compares it field by field.
// Depends on gcdb_pkg and gcdb_intf.
`timescale 1ns / 1ps

module gcdb_checker (
    input  logic       clk,
    input  logic       rst_n,
    gcdb_pt_if         pts,
    gcdb_res_if        res,
    output int         fail_count,
    output int         pending
);

    localparam longint Q1    = 64'sd1073741824;
    localparam longint PI_Q  = 64'sd1686629713;
    localparam longint HPI_Q = 64'sd843314857;
    localparam longint TPI_Q = 64'sd3373259426;

    typedef struct {
        longint dist_cm;
        longint head;
    } geo_result_t;

    geo_result_t expected_q[$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic longint tan_step(input int i);
        longint t [32] = '{421657428, 248918914, 131521918, 66762579, 33510843,
                           16771758, 8387925, 4194219, 2097141, 1048575, 524288,
                           262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048,
                           1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0};
        return t[i];
    endfunction

    task automatic rotate(input longint ang, output longint s, output longint c);
        longint x, y, nx, a;
        bit flip;
        x = 64'sd652032874;
        y = 0;
        a = ang;
        flip = 0;
        while (a > PI_Q)
            a -= TPI_Q;
        while (a <= -PI_Q)
            a += TPI_Q;
        if (a > HPI_Q)
        begin
            a -= PI_Q;
            flip = 1;
        end
        else if (a < -HPI_Q)
        begin
            a += PI_Q;
            flip = 1;
        end
        for (int i = 0; i < gcdb_pkg::CORDIC_STAGES && i < 32; i++)
        begin
            if (a >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                a -= tan_step(i);
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                a += tan_step(i);
            end
            x = nx;
        end
        x = clip(x, -Q1, Q1);
        y = clip(y, -Q1, Q1);
        s = flip ? -y : y;
        c = flip ? -x : x;
    endtask

    // Angle of the vector whose horizontal part is h and vertical part is v.
    function automatic longint vector_angle(input longint v_in, input longint h_in);
        longint v, h, nh, z, off;
        v = v_in;
        h = h_in;
        z = 0;
        off = 0;
        if (v == 0 && h == 0)
            return 0;
        if (h < 0)
        begin
            off = (v >= 0) ? PI_Q : -PI_Q;
            h = -h;
            v = -v;
        end
        while (h < Q1 && v < Q1 && v > -Q1)
        begin
            h *= 2;
            v *= 2;
        end
        for (int i = 0; i < gcdb_pkg::CORDIC_STAGES && i < 32; i++)
        begin
            if (v < 0)
            begin
                nh = h - (v >>> i);
                v = v + (h >>> i);
                z -= tan_step(i);
            end
            else
            begin
                nh = h + (v >>> i);
                v = v - (h >>> i);
                z += tan_step(i);
            end
            h = nh;
        end
        return z + off;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n_in);
        longint unsigned n, r, b;
        n = n_in;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    task automatic predict_route(input longint lat1, input longint lon1,
                                 input longint lat2, input longint lon2,
                                 output geo_result_t r);
        longint s1, c1, s2, c2, sh, ch, sl, cl, sd, cd, hav, z, bx, by;
        longint unsigned ry, rx, d;
        rotate(lat1, s1, c1);
        rotate(lat2, s2, c2);
        rotate((lat2 - lat1) >>> 1, sh, ch);
        rotate((lon2 - lon1) >>> 1, sl, cl);
        rotate(lon2 - lon1, sd, cd);
        hav = clip(qmul(sh, sh) + qmul(qmul(c1, c2), qmul(sl, sl)), 0, Q1);
        ry = int_sqrt(longint'(hav) << 30);
        rx = int_sqrt(longint'(Q1 - hav) << 30);
        z = clip(vector_angle(ry, rx), 0, HPI_Q);
        d = (64'd637100000 * longint'(2 * z) + (64'd1 << 28)) >> 29;
        if (d > 64'd2001508680)
            d = 64'd2001508680;
        bx = qmul(sd, c2);
        by = qmul(c1, s2) - qmul(qmul(s1, c2), cd);
        r.dist_cm = d;
        r.head = clip(HPI_Q - vector_angle(bx, by), -64'sd843314857, 64'sd2529944570);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        geo_result_t r;
        if (rst_n && pts.valid && pts.ready)
        begin
            predict_route(longint'(pts.from_latitude), longint'(pts.from_longitude),
                          longint'(pts.to_latitude), longint'(pts.to_longitude), r);
            expected_q = {expected_q, r};
        end
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected beat", 0, 0);
            else
            begin
                r = expected_q.pop_front();
                if (longint'(res.distance_cm) != r.dist_cm)
                    report_mismatch("distance_cm", longint'(res.distance_cm), r.dist_cm);
                if (longint'(res.heading_from_east) != r.head)
                    report_mismatch("heading_from_east", longint'(res.heading_from_east),
                                    r.head);
            end
        end
    end
endmodule

// ----- verif/tb_great_circle_distance_bearing.sv -----
// Top of the great-circle testbench: clock, reset, point-pair stimulus,
// result backpressure and the verdict. Depends on gcdb_pkg, gcdb_intf, gcdb_checker.
`timescale 1ns / 1ps

module tb_great_circle_distance_bearing;

    localparam longint LAT_MAX = 64'sd843314857;
    localparam longint LON_MAX = 64'sd1686629713;
    localparam int     QUIET_LIMIT = 5000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   stall_pct;
    bit   hold_request;
    int   quiet_cycles;

    gcdb_pt_if  pts ();
    gcdb_res_if res ();

    great_circle_distance_bearing u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .pts   (pts),
        .res   (res)
    );

    gcdb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pts        (pts),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    function automatic longint rand_span(input longint lim);
        return longint'($urandom_range(32'(2 * lim), 0)) - lim;
    endfunction

    task automatic send_pair(input longint lat1, input longint lon1,
                             input longint lat2, input longint lon2);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pts.valid <= 1'b0;
            @(posedge clk);
        end
        pts.valid          <= 1'b1;
        pts.from_latitude  <= lat1[gcdb_pkg::LAT_W-1:0];
        pts.from_longitude <= lon1[gcdb_pkg::LON_W-1:0];
        pts.to_latitude    <= lat2[gcdb_pkg::LAT_W-1:0];
        pts.to_longitude   <= lon2[gcdb_pkg::LON_W-1:0];
        do
            @(posedge clk);
        while (!pts.ready);
    endtask

    task automatic send_random;
        longint a, b, c, d;
        int pick;
        pick = $urandom_range(99);
        a = rand_span(LAT_MAX);
        b = rand_span(LON_MAX);
        c = rand_span(LAT_MAX);
        d = rand_span(LON_MAX);
        if (pick < 12)
        begin
            // Raw bit patterns, including values beyond the stated range.
            a = longint'($urandom());
            b = longint'($urandom());
            c = longint'($urandom());
            d = longint'($urandom());
        end
        else if (pick < 20)
        begin
            c = a;
            d = b;
        end
        else if (pick < 30)
        begin
            c = a + longint'($urandom_range(2000)) - 1000;
            d = b + longint'($urandom_range(2000)) - 1000;
        end
        else if (pick < 36)
        begin
            c = -a;
            d = (b > 0) ? b - LON_MAX : b + LON_MAX;
        end
        send_pair(a, b, c, d);
    endtask

    // Receiver backpressure; a long hold-off is counted here.
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                res.ready <= 1'b0;
                repeat (400)
                    @(posedge clk);
                hold_request = 0;
            end
            res.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pts.valid && pts.ready) || (res.valid && res.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL great_circle_distance_bearing");
            $finish;
        end
    end

    initial
    begin
        int idle_set [4] = '{0, 77, 0, 20};
        int stall_set [4] = '{0, 0, 77, 20};
        pts.valid = 1'b0;
        pts.from_latitude = '0;
        pts.from_longitude = '0;
        pts.to_latitude = '0;
        pts.to_longitude = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_request = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, coincident points, poles, antipodes, zero vector.
        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
        send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(-LAT_MAX, 0, LAT_MAX, 0);
        send_pair(0, -LON_MAX, 0, LON_MAX);
        send_pair(0, LON_MAX, 0, -LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, 0, 0, -LON_MAX);
        send_pair(LAT_MAX, 12345, LAT_MAX, -98765);
        send_pair(0, 0, 1, 0);
        send_pair(0, 0, 0, 1);
        send_pair(0, 0, -1, -1);
        send_pair(64'sh3FFFFFFF, 64'sh7FFFFFFF, -64'sh40000000, -64'sh80000000);
        send_pair(-64'sh40000000, -64'sh80000000, 64'sh3FFFFFFF, 64'sh7FFFFFFF);
        send_pair(-1, -1, -1, -1);
        send_pair(300000000, -1000000000, -200000000, 1500000000);
        send_pair(300000000, 1000000000, 300000000, 1000000000 + LON_MAX);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            if (ph == 0)
                hold_request = 1;
            for (int k = 0; k < 200; k++)
                send_random();
        end
        pts.valid <= 1'b0;
        stall_pct = 20;
        while (pending != 0)
            @(posedge clk);
        repeat (150)
            @(posedge clk);
        if (fail_count == 0)
            $display("PASS great_circle_distance_bearing");
        else
            $display("FAIL great_circle_distance_bearing");
        $finish;
    end
endmodule
